[src/rwc_pkg.sv]
// Shared types and constants for the RGBA window convolution block.
`default_nettype none
package rwc_pkg;

	localparam int MAX_WINDOW_DEF = 11;
	localparam int MAX_LINE_DEF   = 4096;
	localparam int MAX_HEIGHT     = 4096;
	localparam int ROW_W          = 13;
	localparam int CFG_W          = 13;

	localparam logic [1:0] CFG_KIND   = 2'd0;
	localparam logic [1:0] CFG_WINDOW = 2'd1;
	localparam logic [1:0] CFG_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_HEIGHT = 2'd3;

	localparam logic [1:0] KIND_IDENT = 2'd0;
	localparam logic [1:0] KIND_BLUR  = 2'd1;
	localparam logic [1:0] KIND_EDGE  = 2'd2;

	localparam logic MODE_PIXEL = 1'b0;

	typedef struct packed {
		logic       mode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       frame_end;
	} out_beat_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic shift;
	} cell_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

[src/rwc_cell.sv]
// One row accumulator cell of the window sum chain.
`default_nettype none
module rwc_cell import rwc_pkg::*; #(
	parameter int SUM_W = 12
) (
	input  wire logic                  clk,
	input  cell_ctl_t                  ctl,
	input  wire logic [2:0][7:0]       pix,
	input  wire logic [2:0][SUM_W-1:0] prev,
	output logic      [2:0][SUM_W-1:0] sum
);

	logic [2:0][SUM_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (ctl.clear) begin
				sum_q[c] <= '0;
			end else if (ctl.shift) begin
				sum_q[c] <= prev[c];
			end else if (ctl.add) begin
				sum_q[c] <= sum_q[c] + SUM_W'(pix[c]);
			end
		end
	end

	assign sum = sum_q;

endmodule
`default_nettype wire

[src/rwc_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rwc_div import rwc_pkg::*; #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [7:0]       quo,
	output div_stat_t             stat
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [DEN_W:0]   rem_q, rem_sh, rem_nx;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign quo       = quo_q[7:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

[src/rgba_window_convolution_top.sv]
// RGBA window convolution: line store, row accumulator chain, result stage.
// Usage:
//  Input beats on in_valid/in_stall/in_data, results on out_valid/out_stall/out_data.
//  Pixels arrive in raster order; the result for pixel k leaves on the beat
//  numbered k + half*width + half of the frame; drain beats push out the tail.
//  A beat that produces a result is worked through before the next accept:
//  the window is read one pixel per cycle from the single read port of the
//  line store, summed into one accumulator cell per window row, then the
//  row sums ride the chain into the total; for box blur the serial divider
//  runs last. A beat with no result is taken with the block left idle.
//  in_stall is high while a beat is in work. The result register holds one
//  finished beat; a new input beat is taken while it waits, and the block
//  holds in its final step only if the receiver still stalls the older one.
//  Reset: registers return to blur, window 11, 1024 x 1024, frame at start.
//  The line store needs no clearing; every read hits a pixel of this frame.
//  A configuration write restarts the frame.
`default_nettype none
module rgba_window_convolution_top import rwc_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int MAX_LINE   = MAX_LINE_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_beat_t             out_data,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SLOT_W = $clog2(MAX_WINDOW + 1);
	localparam int COL_W  = $clog2(MAX_LINE);
	localparam int LW     = $clog2(MAX_LINE + 1);
	localparam int RS_W   = $clog2(MAX_WINDOW * 255 + 1);
	localparam int TS_W   = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
	localparam int CNT_W  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int ED_W   = CNT_W + 9;
	localparam int LAT_W  = $clog2((MAX_WINDOW / 2) * MAX_LINE + MAX_WINDOW / 2 + 1) + 1;
	localparam int AW     = SLOT_W + COL_W;
	localparam int DEPTH  = 2 ** AW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_WAIT, ST_SHIFT, ST_CALC, ST_DIV, ST_FIN
	} state_t;

	state_t state_q;

	logic [1:0]       kind_q;
	logic [3:0]       wsize_q;
	logic [CFG_W-1:0] width_q, height_q;

	logic [3:0]       ws_lim;
	logic [WIN_W-1:0] win, half;
	logic [LW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;
	logic [LAT_W-1:0] lat;

	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;
	logic [LAT_W:0]   item_q, item_nx;

	logic [WIN_W-1:0] dy_q, dx_q, sh_q, row_s1;
	logic             rv_s1, ctr_s1;
	logic [CNT_W-1:0] cnt_q;

	logic [31:0] mem [DEPTH];
	logic [31:0] mem_q, ctr_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en, rd_en;

	logic in_fire, inputs_done, counted, col_last, out_last, out_free, restart;

	logic signed [ROW_W+1:0] ys;
	logic signed [LW+1:0]    xs;
	logic [ROW_W-1:0]        yc;
	logic [LW-1:0]           xc;

	cell_ctl_t                         cctl [MAX_WINDOW];
	logic [MAX_WINDOW-1:0][2:0][RS_W-1:0] csum;
	logic [2:0][7:0]                   pix_s1;
	logic [2:0][TS_W-1:0]              total_q;
	logic [2:0][7:0]                   res_q, edge_res, quo;
	div_stat_t                         dstat [3];
	logic                              div_start;
	out_beat_t                         out_q;
	logic                              out_valid_q;

	// effective configuration
	always_comb begin
		ws_lim = (wsize_q > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW) : wsize_q;
		if (ws_lim == 4'd0) ws_lim = 4'd1;
		if (!ws_lim[0]) ws_lim = ws_lim - 4'd1;
		win  = WIN_W'(ws_lim);
		half = win >> 1;
		if (width_q == '0) eff_w = LW'(1);
		else if ({1'b0, width_q} > 14'(MAX_LINE)) eff_w = LW'(MAX_LINE);
		else eff_w = LW'(width_q);
		if (height_q == '0) eff_h = ROW_W'(1);
		else if (height_q > CFG_W'(MAX_HEIGHT)) eff_h = ROW_W'(MAX_HEIGHT);
		else eff_h = ROW_W'(height_q);
		lat = LAT_W'(((WIN_W + LW)'(half) * (WIN_W + LW)'(eff_w)) + (WIN_W + LW)'(half));
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign in_fire     = in_valid && !in_stall;
	assign inputs_done = (in_row_q >= eff_h);
	assign counted     = inputs_done || (in_data.mode == MODE_PIXEL);
	assign col_last    = (LW'(in_col_q) == eff_w - 1'b1);
	assign item_nx     = (item_q <= (LAT_W + 1)'(lat)) ? item_q + 1'b1 : item_q;
	assign out_last    = (out_row_q == eff_h - 1'b1) && (LW'(out_col_q) == eff_w - 1'b1);
	assign out_free    = !out_valid_q || !out_stall;
	assign restart     = cfg_we;

	assign wr_en   = in_fire && !inputs_done && (in_data.mode == MODE_PIXEL);
	assign wr_addr = {in_row_q[SLOT_W-1:0], in_col_q};
	assign rd_en   = (state_q == ST_READ);

	// clamped window coordinates
	always_comb begin
		ys = $signed({2'b00, out_row_q}) - $signed((ROW_W + 2)'(half))
			+ $signed((ROW_W + 2)'(dy_q));
		xs = $signed((LW + 2)'(out_col_q)) - $signed((LW + 2)'(half))
			+ $signed((LW + 2)'(dx_q));
		if (ys < 0) yc = '0;
		else if (ys > $signed({2'b00, eff_h - 1'b1})) yc = eff_h - 1'b1;
		else yc = ys[ROW_W-1:0];
		if (xs < 0) xc = '0;
		else if (xs > $signed({2'b00, eff_w - 1'b1})) xc = eff_w - 1'b1;
		else xc = xs[LW-1:0];
		rd_addr = {yc[SLOT_W-1:0], xc[COL_W-1:0]};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {in_data.alpha_in, in_data.blue_in,
				in_data.green_in, in_data.red_in};
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
		end
	end

	assign pix_s1 = mem_q[23:0];

	// row accumulator chain
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		always_comb begin
			cctl[i].clear = in_fire && counted && (item_nx > (LAT_W + 1)'(lat));
			cctl[i].add   = rv_s1 && (row_s1 == WIN_W'(i));
			cctl[i].shift = (state_q == ST_SHIFT);
		end
		if (i == 0) begin : g_head
			rwc_cell #(.SUM_W(RS_W)) u_cell (
				.clk  (clk),
				.ctl  (cctl[i]),
				.pix  (pix_s1),
				.prev ('0),
				.sum  (csum[i])
			);
		end else begin : g_body
			rwc_cell #(.SUM_W(RS_W)) u_cell (
				.clk  (clk),
				.ctl  (cctl[i]),
				.pix  (pix_s1),
				.prev (csum[i-1]),
				.sum  (csum[i])
			);
		end
	end

	assign div_start = (state_q == ST_CALC) && (kind_q == KIND_BLUR);

	for (genvar c = 0; c < 3; c++) begin : g_div
		rwc_div #(.NUM_W(TS_W), .DEN_W(CNT_W)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.num    (total_q[c]),
			.den    (cnt_q),
			.quo    (quo[c]),
			.stat   (dstat[c])
		);
	end

	// count*centre - sum, clipped to a byte
	always_comb begin
		logic [CNT_W+7:0]       prod;
		logic signed [ED_W-1:0] diff;
		for (int c = 0; c < 3; c++) begin
			prod = (CNT_W + 8)'(cnt_q) * (CNT_W + 8)'(ctr_q[8*c +: 8]);
			diff = $signed(ED_W'(prod)) - $signed(ED_W'(total_q[c]));
			if (diff < 0) edge_res[c] = 8'd0;
			else if (diff > $signed(ED_W'(255))) edge_res[c] = 8'd255;
			else edge_res[c] = diff[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_BLUR;
			wsize_q     <= 4'd11;
			width_q     <= CFG_W'(1024);
			height_q    <= CFG_W'(1024);
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			item_q      <= '0;
			dy_q        <= '0;
			dx_q        <= '0;
			sh_q        <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (wr_en) begin
							if (col_last) begin
								in_col_q <= '0;
								in_row_q <= in_row_q + 1'b1;
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						if (counted) begin
							item_q <= item_nx;
							if (item_nx > (LAT_W + 1)'(lat)) begin
								dy_q    <= '0;
								dx_q    <= '0;
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_READ: begin
					if (dx_q == win - 1'b1) begin
						dx_q <= '0;
						if (dy_q == win - 1'b1) state_q <= ST_WAIT;
						else dy_q <= dy_q + 1'b1;
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				ST_WAIT: begin
					sh_q    <= '0;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					sh_q <= sh_q + 1'b1;
					if (sh_q == WIN_W'(MAX_WINDOW - 1)) state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= (kind_q == KIND_BLUR) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (dstat[0].done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (out_last) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
							item_q    <= '0;
						end else if (LW'(out_col_q) == eff_w - 1'b1) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (restart) begin
				case (cfg_index)
					CFG_KIND:   kind_q   <= cfg_data[1:0];
					CFG_WINDOW: wsize_q  <= cfg_data[3:0];
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default:    kind_q   <= kind_q;
				endcase
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				item_q    <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		row_s1 <= dy_q;
		ctr_s1 <= (dy_q == half) && (dx_q == half);
		if (rv_s1 && ctr_s1) ctr_q <= mem_q;
		if (in_fire) cnt_q <= CNT_W'(win) * CNT_W'(win);
		if (cctl[0].clear) begin
			total_q <= '0;
		end else if (state_q == ST_SHIFT) begin
			for (int c = 0; c < 3; c++) begin
				total_q[c] <= total_q[c] + TS_W'(csum[MAX_WINDOW-1][c]);
			end
		end
		if (state_q == ST_CALC) begin
			if (kind_q == KIND_EDGE) res_q <= edge_res;
			else res_q <= ctr_q[23:0];
		end
		if (state_q == ST_DIV && dstat[0].done) res_q <= quo;
		if (state_q == ST_FIN && out_free) begin
			out_q.red_out   <= res_q[0];
			out_q.green_out <= res_q[1];
			out_q.blue_out  <= res_q[2];
			out_q.alpha_out <= ctr_q[31:24];
			out_q.frame_end <= out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_rd_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == ST_READ || state_q == ST_WAIT))
		else $error("read data outside window read");
	a_shift_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> !rv_s1)
		else $error("chain shift while a pixel is still landing");
	a_out_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q < eff_h)
		else $error("output row past frame");
	a_in_col: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(in_col_q) < eff_w)
		else $error("input column past line");
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dstat[0].busy |-> (state_q == ST_DIV))
		else $error("divider running outside divide step");

endmodule
`default_nettype wire

[test/rgba_window_convolution_top_test.sv]
// Self-checking testbench for the RGBA window convolution block.
`timescale 1ns / 100ps
`default_nettype none
module rgba_window_convolution_top_test;
	import rwc_pkg::*;

	localparam int PIX_DEPTH = (MAX_WINDOW_DEF + 1) * MAX_LINE_DEF;
	localparam int SETTLE_CYCLES = 400;
	localparam int CUT_MAX = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_KIND;
	logic [CFG_W-1:0] cfg_data = '0;

	rgba_window_convolution_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	in_beat_t pixel_q[$];
	out_beat_t filtered_q[$];
	int send_idle_pct = 8;
	int recv_idle_pct = 47;
	int pushed = 0;
	bit failed = 0;

	// shadow copy of the filter state
	logic [31:0] pix_mem [0:PIX_DEPTH-1];
	logic [1:0] sh_kind = KIND_BLUR;
	logic [3:0] sh_window = 4'd11;
	logic [12:0] sh_width = 13'd1024;
	logic [12:0] sh_height = 13'd1024;
	int col_pos = 0, row_pos = 0, out_pos = 0, beat_cnt = 0;

	function automatic int clip(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int win_side();
		int s;
		s = int'(sh_window);
		if (s > MAX_WINDOW_DEF) s = MAX_WINDOW_DEF;
		if (s == 0) s = 1;
		if (s % 2 == 0) s = s - 1;
		return s;
	endfunction

	function automatic int line_len();
		int s;
		s = int'(sh_width);
		if (s == 0) s = 1;
		if (s > MAX_LINE_DEF) s = MAX_LINE_DEF;
		return s;
	endfunction

	function automatic int frame_rows();
		int s;
		s = int'(sh_height);
		if (s == 0) s = 1;
		if (s > MAX_HEIGHT) s = MAX_HEIGHT;
		return s;
	endfunction

	task automatic restart_frame();
		col_pos = 0;
		row_pos = 0;
		out_pos = 0;
		beat_cnt = 0;
	endtask

	// advance the shadow state by one accepted beat, queue any result
	task automatic filter_beat(input in_beat_t b);
		int w, h, win, half, n, lat, r, c, y, x, cnt, v;
		int sum[3];
		logic [31:0] centre, p;
		out_beat_t o;
		logic [7:0] res[3];
		w = line_len();
		h = frame_rows();
		win = win_side();
		half = win / 2;
		n = w * h;
		lat = half * w + half;
		if (row_pos < h) begin
			if (b.mode != MODE_PIXEL) return;
			pix_mem[(row_pos * w + col_pos) % PIX_DEPTH] =
				{b.alpha_in, b.blue_in, b.green_in, b.red_in};
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end
		beat_cnt++;
		if (beat_cnt <= lat || out_pos >= n) return;
		r = out_pos / w;
		c = out_pos % w;
		sum = '{0, 0, 0};
		for (int dy = -half; dy <= half; dy++) begin
			y = clip(r + dy, h - 1);
			for (int dx = -half; dx <= half; dx++) begin
				x = clip(c + dx, w - 1);
				p = pix_mem[(y * w + x) % PIX_DEPTH];
				for (int ch = 0; ch < 3; ch++) sum[ch] += int'(p[8*ch +: 8]);
			end
		end
		centre = pix_mem[out_pos % PIX_DEPTH];
		cnt = win * win;
		for (int ch = 0; ch < 3; ch++) begin
			case (sh_kind)
				KIND_BLUR: res[ch] = 8'(sum[ch] / cnt);
				KIND_EDGE: begin
					v = cnt * int'(centre[8*ch +: 8]) - sum[ch];
					res[ch] = 8'(clip(v, 255));
				end
				default: res[ch] = centre[8*ch +: 8];
			endcase
		end
		o.red_out = res[0];
		o.green_out = res[1];
		o.blue_out = res[2];
		o.alpha_out = centre[31:24];
		out_pos++;
		o.frame_end = (out_pos >= n);
		if (o.frame_end) restart_frame();
		filtered_q.push_back(o);
	endtask

	// driver: predicts each accepted beat, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) filter_beat(in_data);
			if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pixel_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_q.size() == 0) begin
					$display("%0t unexpected beat: expected none actual %p", $time,
						out_data);
					failed = 1;
				end else if (filtered_q[0] !== out_data) begin
					$display("%0t mismatch: expected %p actual %p", $time,
						filtered_q[0], out_data);
					failed = 1;
					void'(filtered_q.pop_front());
				end else begin
					void'(filtered_q.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic wait_idle();
		while (pixel_q.size() > 0 || in_valid || filtered_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_KIND: sh_kind = val[1:0];
			CFG_WINDOW: sh_window = val[3:0];
			CFG_WIDTH: sh_width = val;
			default: sh_height = val;
		endcase
		restart_frame();
	endtask

	function automatic in_beat_t rand_pixel(int extreme_pct);
		in_beat_t b;
		b.mode = MODE_PIXEL;
		b.red_in = 8'($urandom);
		b.green_in = 8'($urandom);
		b.blue_in = 8'($urandom);
		b.alpha_in = 8'($urandom);
		if ($urandom_range(99) < extreme_pct) begin
			b.red_in = $urandom_range(1) ? 8'hff : 8'h00;
			b.green_in = $urandom_range(1) ? 8'hff : 8'h00;
			b.blue_in = $urandom_range(1) ? 8'hff : 8'h00;
		end
		return b;
	endfunction

	// one frame: pixels with stray drain beats, then the drain tail;
	// a cut frame stops early and is restarted by the next config write
	task automatic run_frame(input logic [1:0] kind, input logic [3:0] win,
			input logic [12:0] w, input logic [12:0] h, input int noise_pct,
			input bit cut);
		int n, lat, npix;
		in_beat_t b;
		wait_idle();
		write_reg(CFG_KIND, CFG_W'(kind));
		write_reg(CFG_WINDOW, CFG_W'(win));
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		n = line_len() * frame_rows();
		lat = (win_side() / 2) * line_len() + win_side() / 2;
		npix = cut ? int'($urandom_range((n < CUT_MAX) ? n : CUT_MAX)) : n;
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(99) < noise_pct) begin
				b = rand_pixel(0);
				b.mode = ~MODE_PIXEL;
				pixel_q.push_back(b);
			end
			pixel_q.push_back(rand_pixel(30));
			pushed++;
		end
		if (cut) return;
		// pixel beats in the tail count as drain beats
		for (int i = 0; i < lat; i++) begin
			b = rand_pixel(0);
			if ($urandom_range(99) >= noise_pct) b.mode = ~MODE_PIXEL;
			pixel_q.push_back(b);
			pushed++;
		end
	endtask

	task automatic random_frames(input int upto);
		while (pushed < upto) begin
			run_frame(2'($urandom_range(3)), 4'($urandom_range(15)),
				($urandom_range(9) == 0) ? 13'($urandom_range(40)) :
					13'($urandom_range(12)),
				13'($urandom_range(6)), $urandom_range(1) ? 0 : 10,
				$urandom_range(19) == 0);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// a few pixels under the reset setup: far too few for any result
		for (int i = 0; i < 20; i++) pixel_q.push_back(rand_pixel(30));
		// directed: every kind, odd window cases, edges of the raster
		run_frame(KIND_IDENT, 4'd3, 13'd3, 13'd3, 0, 0);
		run_frame(KIND_BLUR, 4'd3, 13'd4, 13'd3, 20, 0);
		run_frame(KIND_EDGE, 4'd3, 13'd3, 13'd2, 0, 0);
		run_frame(2'd3, 4'd1, 13'd2, 13'd2, 0, 0);
		run_frame(KIND_BLUR, 4'd0, 13'd0, 13'd0, 0, 0);
		run_frame(KIND_EDGE, 4'd4, 13'd1, 13'd3, 0, 0);
		run_frame(KIND_BLUR, 4'd15, 13'd2, 13'd1, 30, 0);
		random_frames(600);
		send_idle_pct = 47;
		recv_idle_pct = 8;
		random_frames(1150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_frames(1550);
		// largest sizes, clamped; the first two cut short
		run_frame(KIND_EDGE, 4'd1, 13'h1fff, 13'd1, 0, 1);
		run_frame(KIND_BLUR, 4'd3, 13'd1, 13'h1fff, 0, 1);
		run_frame(KIND_IDENT, 4'd11, 13'd3, 13'd2, 0, 0);
		wait_idle();
		if (!failed) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
